// File: rtl/core/obb_pkg.sv
// Shared constants and types for the oriented-box pair overlap test.
`default_nettype none

package obb_pkg;

    localparam int NumFields = 12;
    localparam int FldCenterX = 0;
    localparam int FldAxisU = 3;

    localparam int NumAxes = 6;
    localparam int NumTerms = 7;
    localparam int CntW = 3;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN
    } t_back_state;

endpackage

`default_nettype wire

// File: rtl/core/obb_pair_fifo.sv
// Short register queue that carries box pairs from the front to the back.
`default_nettype none

module obb_pair_fifo #(
    parameter int WIDTH = 384,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             s_wr, s_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign s_wr    = i_push && !o_full;
    assign s_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (s_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (s_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (s_wr && !s_rd) begin
            n_count = r_count + 1'b1;
        end else if (s_rd && !s_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/obb_front.sv
// Front end: accepts boxes, holds the first box of a pair, queues complete pairs.
`default_nettype none

module obb_front #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_push,
    output logic                                           o_full,
    input  wire logic [obb_pkg::NumFields*COORD_WIDTH-1:0] i_box,
    output logic                                           o_pair_push,
    output logic [2*obb_pkg::NumFields*COORD_WIDTH-1:0]    o_pair_data,
    input  wire logic                                      i_pair_full
);

    localparam int BOXW = obb_pkg::NumFields * COORD_WIDTH;

    logic            r_second_expected;
    logic [BOXW-1:0] r_held;
    logic            s_accept;

    assign o_full      = r_second_expected && i_pair_full;
    assign s_accept    = i_push && !o_full;
    assign o_pair_push = s_accept && r_second_expected;
    assign o_pair_data = {i_box, r_held};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_expected <= 1'b0;
        end else if (s_accept) begin
            r_second_expected <= !r_second_expected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && !r_second_expected) begin
            r_held <= i_box;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/obb_back.sv
// Back end: shared three-multiplier dot-product unit sequenced over the six face axes.
`default_nettype none

module obb_back #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_pair_valid,
    input  wire logic [2*obb_pkg::NumFields*COORD_WIDTH-1:0] i_pair_data,
    output logic                                             o_pair_pop,
    input  wire logic                                        i_pop,
    output logic                                             o_empty,
    output logic                                             o_boxes_overlap
);

    localparam int CW   = COORD_WIDTH;
    localparam int BOXW = obb_pkg::NumFields * CW;
    localparam int DW   = CW + 1;
    localparam int PW   = DW + CW;
    localparam int DTW  = PW + 2;
    localparam int SW   = DTW + 3;
    localparam int NW   = obb_pkg::CntW;

    obb_pkg::t_back_state r_state, n_state;

    logic [NW-1:0] r_ax, n_ax;
    logic [NW-1:0] r_term, n_term;
    logic          s_start, s_issue, s_last;

    logic [BOXW-1:0] s_box_a, s_box_b, s_e_box, s_x_box;
    logic [1:0]      s_e_k, s_x_k;
    logic [3:0]      s_e_base, s_x_base;
    logic signed [CW-1:0] s_e [3];
    logic signed [DW-1:0] s_x [3];

    logic signed [PW-1:0] r_p [3];
    logic                 r_s1_valid, r_s1_first, r_s1_last_axis, r_s1_final;

    logic signed [DTW-1:0] s_sum;
    logic [DTW-1:0]        r_mag;
    logic                  r_s2_valid, r_s2_first, r_s2_last_axis, r_s2_final;

    logic [DTW-1:0] r_lhs;
    logic [SW-1:0]  r_rhs, s_rhs_next;
    logic           r_sep, s_sep_axis, s_done;
    logic           r_out_valid, r_out_overlap;

    assign s_box_a = i_pair_data[BOXW-1:0];
    assign s_box_b = i_pair_data[2*BOXW-1:BOXW];
    assign s_last  = (r_ax == NW'(obb_pkg::NumAxes - 1)) &&
                     (r_term == NW'(obb_pkg::NumTerms - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            obb_pkg::BK_IDLE: begin
                if (i_pair_valid && !r_out_valid) begin
                    n_state = obb_pkg::BK_RUN;
                end
            end
            obb_pkg::BK_RUN: begin
                if (s_last) begin
                    n_state = obb_pkg::BK_DRAIN;
                end
            end
            obb_pkg::BK_DRAIN: begin
                if (s_done) begin
                    n_state = obb_pkg::BK_IDLE;
                end
            end
            default: n_state = obb_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        s_start    = 1'b0;
        s_issue    = 1'b0;
        o_pair_pop = 1'b0;
        case (r_state)
            obb_pkg::BK_IDLE: s_start = i_pair_valid && !r_out_valid;
            obb_pkg::BK_RUN: begin
                s_issue    = 1'b1;
                o_pair_pop = s_last;
            end
            default: begin
                s_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_ax   = r_ax;
        n_term = r_term;
        if (s_start) begin
            n_ax   = '0;
            n_term = '0;
        end else if (s_issue) begin
            if (r_term == NW'(obb_pkg::NumTerms - 1)) begin
                n_term = '0;
                n_ax   = r_ax + 1'b1;
            end else begin
                n_term = r_term + 1'b1;
            end
        end
    end

    // operand select: axis vector by r_ax, projected vector by r_term
    always_comb begin
        s_e_box  = (r_ax < NW'(3)) ? s_box_a : s_box_b;
        s_e_k    = (r_ax < NW'(3)) ? r_ax[1:0] : 2'(r_ax - NW'(3));
        s_e_base = 4'(obb_pkg::FldAxisU) + 4'(3 * s_e_k);
        s_x_box  = r_term[0] ? s_box_a : s_box_b;
        s_x_k    = 2'((r_term - 1'b1) >> 1);
        s_x_base = 4'(obb_pkg::FldAxisU) + 4'(3 * s_x_k);
        for (int j = 0; j < 3; j++) begin
            s_e[j] = s_e_box[(s_e_base + 4'(j))*CW +: CW];
            if (r_term == '0) begin
                s_x[j] = $signed({s_box_b[(obb_pkg::FldCenterX + j)*CW + CW-1],
                                  s_box_b[(obb_pkg::FldCenterX + j)*CW +: CW]})
                       - $signed({s_box_a[(obb_pkg::FldCenterX + j)*CW + CW-1],
                                  s_box_a[(obb_pkg::FldCenterX + j)*CW +: CW]});
            end else begin
                s_x[j] = $signed({s_x_box[(s_x_base + 4'(j))*CW + CW-1],
                                  s_x_box[(s_x_base + 4'(j))*CW +: CW]});
            end
        end
    end

    always_comb begin
        s_sum = DTW'(r_p[0]) + DTW'(r_p[1]) + DTW'(r_p[2]);
    end

    assign s_rhs_next = r_rhs + SW'(r_mag);
    assign s_sep_axis = r_s2_last_axis && (SW'(r_lhs) > s_rhs_next);
    assign s_done     = r_s2_valid && r_s2_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= obb_pkg::BK_IDLE;
            r_ax        <= '0;
            r_term      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ax       <= n_ax;
            r_term     <= n_term;
            r_s1_valid <= s_issue;
            r_s2_valid <= r_s1_valid;
            if (s_done) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_p[j] <= s_x[j] * s_e[j];
        end
        r_s1_first     <= (r_term == '0);
        r_s1_last_axis <= (r_term == NW'(obb_pkg::NumTerms - 1));
        r_s1_final     <= s_last;

        r_mag          <= s_sum[DTW-1] ? DTW'(-s_sum) : DTW'(s_sum);
        r_s2_first     <= r_s1_first;
        r_s2_last_axis <= r_s1_last_axis;
        r_s2_final     <= r_s1_final;

        if (s_start) begin
            r_sep <= 1'b0;
        end else if (r_s2_valid) begin
            r_sep <= r_sep || s_sep_axis;
        end
        if (r_s2_valid) begin
            if (r_s2_first) begin
                r_lhs <= r_mag;
                r_rhs <= '0;
            end else begin
                r_rhs <= s_rhs_next;
            end
        end
        if (s_done) begin
            r_out_overlap <= !(r_sep || s_sep_axis);
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_boxes_overlap = r_out_overlap;

`ifndef SYNTHESIS
    a_write_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done |-> !r_out_valid)
        else $error("result written while previous result still waiting");
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == obb_pkg::BK_IDLE) |-> (!r_s1_valid && !r_s2_valid))
        else $error("dot-product pipeline busy while idle");
    a_issue_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_issue |-> i_pair_valid)
        else $error("dot product issued without a queued pair");
    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == obb_pkg::BK_DRAIN))
        else $error("result appeared outside drain");
`endif

endmodule

`default_nettype wire

// File: rtl/core/obb_pair_overlap_test.sv
// Each pair runs a start step, then 42 three-term dot products one per cycle, then a drain
//   through the s1 and s2 registers; the next pair starts only after its result is popped.
// A first box is never stalled; a two-entry pair queue decouples input from the unit.
// Reset (synchronous, active low) empties the queue and result slot, expects a first box.
// Top level: oriented-box pair overlap test on the six face axes.
`default_nettype none

module obb_pair_overlap_test #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_u_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_u_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_u_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_v_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_v_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_v_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_w_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_w_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_axis_w_z,
    input  wire logic                          pop,
    output logic                               empty,
    output logic                               o_boxes_overlap
);

    localparam int BOXW = obb_pkg::NumFields * COORD_WIDTH;

    logic [BOXW-1:0]   s_box;
    logic              s_pair_push, s_pair_full, s_pair_valid, s_pair_pop;
    logic [2*BOXW-1:0] s_pair_wdata, s_pair_rdata;

    assign s_box = {i_axis_w_z, i_axis_w_y, i_axis_w_x,
                    i_axis_v_z, i_axis_v_y, i_axis_v_x,
                    i_axis_u_z, i_axis_u_y, i_axis_u_x,
                    i_center_z, i_center_y, i_center_x};

    obb_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_box      (s_box),
        .o_pair_push(s_pair_push),
        .o_pair_data(s_pair_wdata),
        .i_pair_full(s_pair_full)
    );

    obb_pair_fifo #(
        .WIDTH(2 * BOXW),
        .DEPTH(2)
    ) u_pair_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s_pair_push),
        .i_data (s_pair_wdata),
        .o_full (s_pair_full),
        .i_pop  (s_pair_pop),
        .o_valid(s_pair_valid),
        .o_data (s_pair_rdata)
    );

    obb_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pair_valid   (s_pair_valid),
        .i_pair_data    (s_pair_rdata),
        .o_pair_pop     (s_pair_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_boxes_overlap(o_boxes_overlap)
    );

endmodule

`default_nettype wire

// File: tb/sv/obb_pair_overlap_test_tb.sv
// Testbench for the oriented-box pair overlap test: random bursts, scoreboard check.
`timescale 1ns / 1ps

module obb_pair_overlap_test_tb;

    localparam int COORD_W = 16;
    localparam int NUM_PAIRS = 700;
    localparam int DRAIN_CYCLES = 120;

    typedef logic [0:obb_pkg::NumFields-1][COORD_W-1:0] t_box;

    // Holds box A of each pair and queues the overlap flag predicted for each pair.
    class overlap_board;
        t_box held_a;
        bit   have_a;
        bit   overlap_q[$];
        int   errors;

        static function longint comp(t_box b, int idx);
            return longint'($signed(b[idx]));
        endfunction

        static function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        static function longint proj(t_box b, int base, longint e0, longint e1, longint e2);
            return comp(b, base) * e0 + comp(b, base + 1) * e1 + comp(b, base + 2) * e2;
        endfunction

        // Face-axis separation test with unnormalized axes, exact in 64 bits.
        static function bit pair_overlaps(t_box a, t_box b);
            longint d0, d1, d2, e0, e1, e2, lhs, rhs;
            t_box src;
            d0 = comp(b, obb_pkg::FldCenterX) - comp(a, obb_pkg::FldCenterX);
            d1 = comp(b, obb_pkg::FldCenterX + 1) - comp(a, obb_pkg::FldCenterX + 1);
            d2 = comp(b, obb_pkg::FldCenterX + 2) - comp(a, obb_pkg::FldCenterX + 2);
            for (int ax = 0; ax < obb_pkg::NumAxes; ax++) begin
                src = (ax < 3) ? a : b;
                e0 = comp(src, obb_pkg::FldAxisU + 3 * (ax % 3));
                e1 = comp(src, obb_pkg::FldAxisU + 3 * (ax % 3) + 1);
                e2 = comp(src, obb_pkg::FldAxisU + 3 * (ax % 3) + 2);
                lhs = mag(d0 * e0 + d1 * e1 + d2 * e2);
                rhs = 0;
                for (int k = 0; k < 3; k++) begin
                    rhs += mag(proj(a, obb_pkg::FldAxisU + 3 * k, e0, e1, e2));
                    rhs += mag(proj(b, obb_pkg::FldAxisU + 3 * k, e0, e1, e2));
                end
                if (lhs > rhs) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void note_box(t_box b);
            if (!have_a) begin
                held_a = b;
                have_a = 1'b1;
            end else begin
                overlap_q.push_back(pair_overlaps(held_a, b));
                have_a = 1'b0;
            end
        endfunction

        function void check_overlap(bit got);
            bit want;
            if (overlap_q.size() == 0) begin
                report($sformatf("unexpected transaction: boxes_overlap=%0b", got));
                return;
            end
            want = overlap_q.pop_front();
            if (got !== want)
                report($sformatf("mismatch: boxes_overlap expected %0b, got %0b", want, got));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty, o_boxes_overlap;
    logic signed [COORD_W-1:0] i_center_x = '0, i_center_y = '0, i_center_z = '0;
    logic signed [COORD_W-1:0] i_axis_u_x = '0, i_axis_u_y = '0, i_axis_u_z = '0;
    logic signed [COORD_W-1:0] i_axis_v_x = '0, i_axis_v_y = '0, i_axis_v_z = '0;
    logic signed [COORD_W-1:0] i_axis_w_x = '0, i_axis_w_y = '0, i_axis_w_z = '0;

    overlap_board sb;
    int burst_left = 0;
    bit steady = 1'b0;
    int rx_cycle = 0;
    int rx_mode = 0;

    obb_pair_overlap_test #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_center_x(i_center_x),
        .i_center_y(i_center_y),
        .i_center_z(i_center_z),
        .i_axis_u_x(i_axis_u_x),
        .i_axis_u_y(i_axis_u_y),
        .i_axis_u_z(i_axis_u_z),
        .i_axis_v_x(i_axis_v_x),
        .i_axis_v_y(i_axis_v_y),
        .i_axis_v_z(i_axis_v_z),
        .i_axis_w_x(i_axis_w_x),
        .i_axis_w_y(i_axis_w_y),
        .i_axis_w_z(i_axis_w_z),
        .pop(pop),
        .empty(empty),
        .o_boxes_overlap(o_boxes_overlap)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_box make_box(int cx, int cy, int cz, int ux, int uy, int uz,
                                      int vx, int vy, int vz, int wx, int wy, int wz);
        return {COORD_W'(cx), COORD_W'(cy), COORD_W'(cz), COORD_W'(ux), COORD_W'(uy),
                COORD_W'(uz), COORD_W'(vx), COORD_W'(vy), COORD_W'(vz), COORD_W'(wx),
                COORD_W'(wy), COORD_W'(wz)};
    endfunction

    function automatic int srand(int lo, int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic t_box noise_box();
        t_box b;
        for (int i = 0; i < obb_pkg::NumFields; i++) b[i] = COORD_W'($urandom());
        return b;
    endfunction

    // Box with random axis components in [-s, s], centered at (cx, cy, cz).
    function automatic t_box scene_box(int s, int cx, int cy, int cz);
        return make_box(cx, cy, cz, srand(-s, s), srand(-s, s), srand(-s, s),
                        srand(-s, s), srand(-s, s), srand(-s, s),
                        srand(-s, s), srand(-s, s), srand(-s, s));
    endfunction

    task automatic send_box(input t_box b);
        int gap;
        i_center_x <= b[obb_pkg::FldCenterX];
        i_center_y <= b[obb_pkg::FldCenterX + 1];
        i_center_z <= b[obb_pkg::FldCenterX + 2];
        i_axis_u_x <= b[obb_pkg::FldAxisU];
        i_axis_u_y <= b[obb_pkg::FldAxisU + 1];
        i_axis_u_z <= b[obb_pkg::FldAxisU + 2];
        i_axis_v_x <= b[obb_pkg::FldAxisU + 3];
        i_axis_v_y <= b[obb_pkg::FldAxisU + 4];
        i_axis_v_z <= b[obb_pkg::FldAxisU + 5];
        i_axis_w_x <= b[obb_pkg::FldAxisU + 6];
        i_axis_w_y <= b[obb_pkg::FldAxisU + 7];
        i_axis_w_z <= b[obb_pkg::FldAxisU + 8];
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        sb.note_box(b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = steady ? 0 : $urandom_range(60, 0);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(8, 0);
        end
    endtask

    // Receiver: the stall pattern is redrawn at random from four modes; each pop is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_overlap(o_boxes_overlap);
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(3, 0);
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= $urandom_range(1, 0);
            2: pop <= (rx_cycle % 8 == 0);
            default: pop <= (rx_cycle % 64 >= 48);
        endcase
    end

    initial begin
        int kind, s, sgn, axis, delta;
        int ca[3], cb[3], h[3], g[3];
        t_box a, b;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-length axes never separate
        send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_box(make_box(-30000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_box(make_box(30000, 100, -5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // touching faces, then one unit apart
        send_box(make_box(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 100));
        send_box(make_box(200, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 100));
        send_box(make_box(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 100));
        send_box(make_box(201, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 100));
        // field extremes
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768, -32768, -32768));
        send_box(make_box(32767, -32768, 32767, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_box(make_box(-32768, 32767, -32768, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_box(make_box(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_box(make_box(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        // degenerate and non-orthogonal axes
        send_box(make_box(0, 0, 0, 50, 50, 0, 50, 50, 0, 50, 50, 0));
        send_box(make_box(300, -300, 0, 10, 0, 0, 0, 10, 0, 0, 0, 10));
        // rotated box against an axis-aligned one
        send_box(make_box(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 100));
        send_box(make_box(180, 180, 0, 70, 70, 0, -70, 70, 0, 0, 0, 100));
        // small box inside a large one
        send_box(make_box(0, 0, 0, 20000, 0, 0, 0, 20000, 0, 0, 0, 20000));
        send_box(make_box(500, -400, 300, 3, 1, 0, -1, 3, 0, 0, 0, 2));

        for (int n = 0; n < NUM_PAIRS - 10; n++) begin
            if (n % 150 == 0) steady = ($urandom_range(2, 0) == 0);
            kind = $urandom_range(99, 0);
            if (kind < 20) begin
                a = noise_box();
                b = noise_box();
            end else if (kind < 40) begin
                axis = $urandom_range(2, 0);
                sgn = $urandom_range(1, 0) ? 1 : -1;
                delta = srand(-1, 1);
                for (int i = 0; i < 3; i++) begin
                    h[i] = srand(1, 4000);
                    g[i] = srand(1, 4000);
                    ca[i] = srand(-12000, 12000);
                    cb[i] = ca[i];
                end
                cb[axis] = ca[axis] + sgn * (h[axis] + g[axis] + delta);
                a = make_box(ca[0], ca[1], ca[2], h[0], 0, 0, 0, h[1], 0, 0, 0, h[2]);
                b = make_box(cb[0], cb[1], cb[2], g[0], 0, 0, 0, g[1], 0, 0, 0, g[2]);
            end else begin
                s = ($urandom_range(9, 0) == 0) ? $urandom_range(3, 0) : srand(1, 4000);
                for (int i = 0; i < 3; i++) begin
                    ca[i] = srand(-16000, 16000);
                    cb[i] = ca[i] + srand(-3 * s, 3 * s);
                end
                a = scene_box(s, ca[0], ca[1], ca[2]);
                b = scene_box(s, cb[0], cb[1], cb[2]);
            end
            send_box(a);
            send_box(b);
        end
        push <= 1'b0;

        while (sb.overlap_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/obb_pkg.sv
rtl/core/obb_pair_fifo.sv
rtl/core/obb_front.sv
rtl/core/obb_back.sv
rtl/core/obb_pair_overlap_test.sv
tb/sv/obb_pair_overlap_test_tb.sv
